// File: hw/rtl/tak_pkg.sv
// shared widths, types and constant tables for the tilt angle kalman filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tak_pkg;

    localparam int ANG_W    = 16;   // q3.13 angle
    localparam int VAR_W    = 24;   // q8.16 variance
    localparam int NOISE_W  = 16;   // q0.16 configuration values
    localparam int K_W      = 17;   // q1.16 gain, 0..65536
    localparam int MUL_A_W  = 25;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int CORDIC_W = 35;   // x/y working width, inputs scaled by 2^16
    localparam int Z_W      = 28;   // angle accumulator, rad * 2^24
    localparam int TAB_LEN  = 24;
    localparam int TAB_IW   = 5;

    localparam logic signed [Z_W-1:0] HALF_PI_S24 = 28'sd26353589;

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic [VAR_W-1:0]        t_var;

    typedef struct packed {
        logic           done;
        logic [K_W-1:0] k;
    } t_div_out;

    typedef struct packed {
        logic   done;
        t_angle meas;
    } t_cordic_out;

    // atan(2^-i) scaled by 2^24
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a 20 bit signed value to the q3.13 range
    function automatic t_angle sat_angle(input logic signed [19:0] v);
        t_angle r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/tilt_angle_kalman_filter.sv
// tilt angle kalman filter: sequencer, state and shared multiplier around a cordic and divider
// depends on tak_pkg, tak_mul, tak_div, tak_cordic
// one beat at a time: input taken only while idle; each step waits on the 17 step divider and the cordic
// reset: synchronous active low; angle and variance to zero, noise and period to 6554
`timescale 1ns / 1ps

module tilt_angle_kalman_filter import tak_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [NOISE_W-1:0] i_cfg_wdata,
    // sample stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,   // accel_x, accel_z, gyro_y
    // estimate stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata    // angle_estimate, angle_variance
);

    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd2;
    localparam logic [NOISE_W-1:0] CFG_RESET = 16'd6554;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED_MUL,   // gyro rate times dt into the multiplier
        S_PRED,       // predicted angle and variance, launch cordic and divider
        S_SOLVE,      // wait for gain and measured angle
        S_CORR_MUL,   // gain times innovation into the multiplier
        S_CORR,       // corrected angle, variance factor into the multiplier
        S_VAR         // variance update and result beat
    } t_state;

    // configuration
    logic [NOISE_W-1:0] r_q;
    logic [NOISE_W-1:0] r_r;
    logic [NOISE_W-1:0] r_dt;

    // sequencer and filter state
    t_state r_state;
    t_angle r_ax;
    t_angle r_az;
    t_angle r_gy;
    t_angle r_angle;
    t_var   r_var;
    t_angle r_pred;
    t_var   r_p;
    logic   r_out_valid;
    t_angle r_out_angle;
    t_var   r_out_var;

    // datapath
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [MUL_P_W-1:0] w_prod_r15;
    logic signed [MUL_P_W-1:0] w_prod_r16;
    logic signed [18:0]        w_rate;
    logic signed [18:0]        w_pred_diff;
    logic signed [19:0]        w_corr_sum;
    logic signed [ANG_W:0]     w_innov;
    logic [VAR_W:0]            w_p_sum;
    t_var                      w_p;
    logic [K_W-1:0]            w_one_minus_k;
    logic                      w_start;
    logic                      w_out_free;
    t_div_out                  w_div;
    t_cordic_out               w_cor;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_var, r_out_angle};
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_start       = (r_state == S_PRED);

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q  <= CFG_RESET;
            r_r  <= CFG_RESET;
            r_dt <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_NOISE: r_q  <= i_cfg_wdata;
                CFG_MEAS_NOISE:    r_r  <= i_cfg_wdata;
                CFG_SAMPLE_PERIOD: r_dt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // predicted variance, saturating at 2^24 - 1
    assign w_p_sum = {1'b0, r_var} + {{(VAR_W + 1 - NOISE_W){1'b0}}, r_q};
    assign w_p     = w_p_sum[VAR_W] ? '1 : w_p_sum[VAR_W-1:0];

    assign w_innov       = {w_cor.meas[ANG_W-1], w_cor.meas} - {r_pred[ANG_W-1], r_pred};
    assign w_one_minus_k = 17'h10000 - w_div.k;

    // one multiplier shared by the three products of a step
    always_comb begin
        unique case (r_state)
            S_PRED_MUL: begin
                w_mul_a = {{(MUL_A_W - ANG_W){r_gy[ANG_W-1]}}, r_gy};
                w_mul_b = {{(MUL_B_W - NOISE_W){1'b0}}, r_dt};
            end
            S_CORR_MUL: begin
                w_mul_a = {{(MUL_A_W - ANG_W - 1){w_innov[ANG_W]}}, w_innov};
                w_mul_b = {{(MUL_B_W - K_W){1'b0}}, w_div.k};
            end
            S_CORR: begin
                w_mul_a = {1'b0, r_p};
                w_mul_b = {{(MUL_B_W - K_W){1'b0}}, w_one_minus_k};
            end
            S_VAR: begin
                // keep the variance product alive while the result waits
                w_mul_a = {1'b0, r_p};
                w_mul_b = {{(MUL_B_W - K_W){1'b0}}, w_one_minus_k};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // rounding of the products, half up
    assign w_prod_r15  = w_prod + 43'sd16384;
    assign w_prod_r16  = w_prod + 43'sd32768;
    assign w_rate      = w_prod_r15[33:15];
    assign w_pred_diff = {{3{r_angle[ANG_W-1]}}, r_angle} - w_rate;
    assign w_corr_sum  = {{4{r_pred[ANG_W-1]}}, r_pred} + w_prod_r16[35:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_angle     <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a beat taken in the same cycle as a new result is replaced, not cleared
            if (r_out_valid && m_axis_tready && !(r_state == S_VAR && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ax    <= s_axis_tdata[15:0];
                        r_az    <= s_axis_tdata[31:16];
                        r_gy    <= s_axis_tdata[47:32];
                        r_state <= S_PRED_MUL;
                    end
                end
                S_PRED_MUL: begin
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    r_pred  <= sat_angle({w_pred_diff[18], w_pred_diff});
                    r_p     <= w_p;
                    r_state <= S_SOLVE;
                end
                S_SOLVE: begin
                    if (w_div.done && w_cor.done) begin
                        r_state <= S_CORR_MUL;
                    end
                end
                S_CORR_MUL: begin
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_angle <= sat_angle(w_corr_sum);
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    // hold the finished variance until the output register frees up
                    if (w_out_free) begin
                        r_var       <= w_prod_r16[39:16];
                        r_out_var   <= w_prod_r16[39:16];
                        r_out_angle <= r_angle;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tak_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // divider runs on the predicted variance as it is registered
    tak_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_p     (w_p),
        .i_r     (r_r),
        .o_res   (w_div)
    );

    tak_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ax    (r_ax),
        .i_az    (r_az),
        .o_res   (w_cor)
    );

`ifndef ASSERT_OFF
    // a sample beat closes the input until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a step is running");

    // correction only starts with both gain and measured angle ready
    a_solve_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORR_MUL) |-> (w_div.done && w_cor.done))
        else $error("correction started before divider and cordic finished");

    // updated variance never exceeds the predicted one
    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VAR) && w_out_free |=> m_axis_tvalid && (r_out_var <= r_p))
        else $error("variance update exceeds prediction");
`endif

endmodule

// File: hw/rtl/tak_mul.sv
// shared signed multiplier with registered product
// depends on tak_pkg
`timescale 1ns / 1ps

module tak_mul import tak_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/tak_div.sv
// serial restoring divider for the kalman gain, one quotient bit per cycle
// depends on tak_pkg
`timescale 1ns / 1ps

module tak_div import tak_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_var               i_p,
    input  logic [NOISE_W-1:0] i_r,
    output t_div_out           o_res
);

    localparam int CNT_W = $clog2(K_W);
    localparam logic [CNT_W-1:0] FIRST = CNT_W'(K_W - 1);

    logic [VAR_W+1:0] r_rem;
    logic [VAR_W:0]   r_den;
    logic [K_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic             w_ge;
    logic [VAR_W+1:0] w_rem_sub;

    // zero denominator gives a zero gain
    assign w_ge      = ({1'b0, r_den} <= r_rem) && (r_den != '0);
    assign w_rem_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= FIRST;
            r_q    <= '0;
            r_rem  <= {2'b00, i_p};
            r_den  <= {1'b0, i_p} + {{(VAR_W + 1 - NOISE_W){1'b0}}, i_r};
        end else if (r_busy) begin
            r_q   <= {r_q[K_W-2:0], w_ge};
            r_rem <= {w_rem_sub[VAR_W:0], 1'b0};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.k    = r_q;

endmodule

// File: hw/rtl/tak_cordic.sv
// iterative vectoring cordic for atan2 of the accelerometer axes
// depends on tak_pkg
`timescale 1ns / 1ps

module tak_cordic import tak_pkg::*; #(
    parameter int ITERATIONS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_angle      i_ax,
    input  t_angle      i_az,
    output t_cordic_out o_res
);

    localparam int RUNS = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
    localparam logic [TAB_IW-1:0] LAST = TAB_IW'(RUNS - 1);

    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [Z_W-1:0]      r_z;
    logic [TAB_IW-1:0]          r_cnt;
    logic                       r_busy;
    logic                       r_done;
    t_angle                     r_meas;

    logic signed [CORDIC_W-1:0] w_x0;
    logic signed [CORDIC_W-1:0] w_y0;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [CORDIC_W-1:0] w_x_nx;
    logic signed [CORDIC_W-1:0] w_y_nx;
    logic signed [Z_W-1:0]      w_z_nx;
    logic signed [Z_W-1:0]      w_z_rnd;

    // x is accel_z, y is accel_x, both scaled by 2^16
    assign w_x0 = {{(CORDIC_W - 32){i_az[15]}}, i_az, 16'h0000};
    assign w_y0 = {{(CORDIC_W - 32){i_ax[15]}}, i_ax, 16'h0000};

    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;

    always_comb begin
        if (!r_y[CORDIC_W-1]) begin
            w_x_nx = r_x + w_ys;
            w_y_nx = r_y - w_xs;
            w_z_nx = r_z + atan_entry(r_cnt);
        end else begin
            w_x_nx = r_x - w_ys;
            w_y_nx = r_y + w_xs;
            w_z_nx = r_z - atan_entry(r_cnt);
        end
    end

    // round half up from 2^24 to 2^13
    assign w_z_rnd = w_z_nx + 28'sd1024;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt <= '0;
            if (i_ax == '0 && i_az == '0) begin
                // null vector reads as zero angle
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_meas <= '0;
            end else begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                if (!i_az[15]) begin
                    r_x <= w_x0;
                    r_y <= w_y0;
                    r_z <= '0;
                end else if (!i_ax[15]) begin
                    // upper left quadrant, rotate by -pi/2
                    r_x <= w_y0;
                    r_y <= -w_x0;
                    r_z <= HALF_PI_S24;
                end else begin
                    r_x <= -w_y0;
                    r_y <= w_x0;
                    r_z <= -HALF_PI_S24;
                end
            end
        end else if (r_busy) begin
            r_x   <= w_x_nx;
            r_y   <= w_y_nx;
            r_z   <= w_z_nx;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_meas <= w_z_rnd[ANG_W+10:11];
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.meas = r_meas;

endmodule

// File: test/testbench.sv
// self-checking bench for tilt_angle_kalman_filter: imu sample beats in, angle/variance beats out
// depends on tak_pkg for widths and types; holds its own fixed-point filter and cordic predictor
`timescale 1ns / 1ps

module testbench;
    import tak_pkg::*;

    localparam int     CORDIC_STEPS = 14;
    localparam longint VARIANCE_MAX = (longint'(1) << VAR_W) - 1;
    localparam longint ANGLE_MAX    = 32767;
    localparam longint ANGLE_MIN    = -32768;

    // configuration register map
    localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD     = 2'd2;
    localparam logic [1:0] REG_UNUSED            = 2'd3;

    // sample beat, accel_x in the low bits
    typedef struct packed {
        logic signed [15:0] gyro_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_x;
    } t_imu_sample;

    // estimate beat, angle in the low bits
    typedef struct packed {
        t_var   variance;
        t_angle angle;
    } t_estimate;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_idx     = '0;
    logic [NOISE_W-1:0] i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata  = '0;   // accel_x, accel_z, gyro_y
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;         // angle_estimate, angle_variance

    tilt_angle_kalman_filter #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // filter state and registers as the predictor sees them
    longint cfg_process_noise     = 6554;
    longint cfg_measurement_noise = 6554;
    longint cfg_sample_period     = 6554;
    longint angle_now             = 0;
    longint variance_now          = 0;

    // atan(2^-i) in rad * 2^24
    longint atan_s24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    t_estimate pending_estimates [$];
    int        mismatches  = 0;
    int        stall_left  = 0;
    bit        steady_flow = 1'b0;   // no gaps on either side while set

    // floor shift with round half up
    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > ANGLE_MAX) return ANGLE_MAX;
        if (v < ANGLE_MIN) return ANGLE_MIN;
        return v;
    endfunction

    // accelerometer tilt, atan2(ax, az) in q3.13 by vectoring cordic
    function automatic longint accel_tilt(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 65536;
        y = y * 65536;
        // left half plane: turn the vector by a quarter first
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(HALF_PI_S24);
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_S24);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_s24[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_s24[i];
            end
        end
        return round_shr(z, 11);
    endfunction

    // one filter step: predict, gain, correct; updates the tracked state
    function automatic t_estimate kalman_step(t_imu_sample s);
        longint ax;
        longint az;
        longint gy;
        longint pred;
        longint p;
        longint denom;
        longint k;
        longint meas;
        t_estimate e;
        ax = s.accel_x;
        az = s.accel_z;
        gy = s.gyro_y;
        pred = clamp_angle(angle_now - round_shr(gy * cfg_sample_period, 15));
        p = variance_now + cfg_process_noise;
        if (p > VARIANCE_MAX) p = VARIANCE_MAX;
        denom = p + cfg_measurement_noise;
        k = (denom == 0) ? 0 : (p << 16) / denom;
        meas = accel_tilt(ax, az);
        angle_now = clamp_angle(pred + round_shr(k * (meas - pred), 16));
        variance_now = (p * (65536 - k) + 32768) >> 16;
        e.angle = t_angle'(angle_now);
        e.variance = t_var'(variance_now);
        return e;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(99) < 85) return $urandom_range(3, 1);
        return $urandom_range(60, 12);
    endfunction

    function automatic logic signed [15:0] extreme_value();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // receiver side: random back pressure, changed at the falling edge
    always @(negedge i_clk) begin
        if (steady_flow) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall_left = gap_length();
            m_axis_tready <= 1'b0;
        end
    end

    // each estimate beat against the oldest prediction
    always @(posedge i_clk) begin
        t_estimate got;
        t_estimate want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: estimate beat with none outstanding: angle %0d variance %0d",
                             $time, got.angle, got.variance);
            end else begin
                want = pending_estimates.pop_front();
                if (got.angle !== want.angle || got.variance !== want.variance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch angle exp %0d got %0d, variance exp %0d got %0d",
                                 $time, want.angle, got.angle, want.variance, got.variance);
                end
            end
        end
    end

    // one sample beat; tvalid stays high afterwards unless the next call opens a gap
    task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                               input logic signed [15:0] gy);
        t_imu_sample s;
        int gap;
        s.accel_x = ax;
        s.accel_z = az;
        s.gyro_y = gy;
        gap = 0;
        if (!steady_flow && $urandom_range(99) >= 55) gap = gap_length();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_estimates.push_back(kalman_step(s));
    endtask

    // random sample with a mix of zero, extreme, small and full-range fields
    task automatic send_random_sample();
        logic signed [15:0] ax;
        logic signed [15:0] az;
        logic signed [15:0] gy;
        ax = 16'($urandom);
        az = 16'($urandom);
        gy = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(int'($urandom_range(1024)) - 512);
        case ($urandom_range(9))
            0: begin
                ax = '0;
                az = '0;
            end
            1: begin
                ax = extreme_value();
                az = extreme_value();
                gy = extreme_value();
            end
            2: begin
                ax = 16'(int'($urandom_range(64)) - 32);
                az = 16'(int'($urandom_range(64)) - 32);
            end
            default: ;
        endcase
        send_sample(ax, az, gy);
    endtask

    // stop sending and hold until every outstanding estimate has come back
    task automatic wait_for_estimates();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0) @(negedge i_clk);
    endtask

    // register write, only called while the filter is idle
    task automatic write_register(input logic [1:0] idx, input logic [NOISE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PROCESS_NOISE:     cfg_process_noise = value;
            REG_MEASUREMENT_NOISE: cfg_measurement_noise = value;
            REG_SAMPLE_PERIOD:     cfg_sample_period = value;
            default: ;   // unmapped index, no effect
        endcase
    endtask

    task automatic write_settings(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r,
                                  input logic [NOISE_W-1:0] dt);
        write_register(REG_PROCESS_NOISE, q);
        write_register(REG_MEASUREMENT_NOISE, r);
        write_register(REG_SAMPLE_PERIOD, dt);
    endtask

    // reset values, accelerometer vectors on the axes and in three quadrants, gyro extremes
    task automatic test_power_on_defaults();
        send_sample(16'sd0, 16'sd0, 16'sd0);               // both accel axes zero
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF, 16'sd0);
        send_sample(16'sd0, 16'sh8000, 16'sd0);            // straight back, angle pi
        send_sample(16'sh8000, 16'sh8000, 16'sd0);         // lower left quadrant
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);      // upper left quadrant
        send_sample(16'sd1, -16'sd1, 16'sh8000);
        send_sample(-16'sd1, 16'sh7FFF, 16'sd1);
    endtask

    // no noise at all: full gain once, then zero variance and zero gain
    task automatic test_zero_noise();
        wait_for_estimates();
        write_settings(16'd0, 16'd0, 16'd6554);
        send_sample(16'sd1000, 16'sd4000, 16'sd100);
        send_sample(16'sd0, 16'sh8000, -16'sd2000);
        send_sample(-16'sd3000, 16'sd500, 16'sh7FFF);
    endtask

    // long period and full-scale rate drive the predicted angle into both limits
    task automatic test_angle_saturation();
        wait_for_estimates();
        write_settings(16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'sd0, 16'sh7FFF, 16'sh8000);
        send_sample(16'sd0, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sd1, 16'sh8000);
        send_sample(16'sd0, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sd1, 16'sh7FFF);
    endtask

    // write to the unmapped index must leave every setting alone
    task automatic test_unmapped_register();
        wait_for_estimates();
        write_settings(16'd6554, 16'd6554, 16'd6554);
        write_register(REG_UNUSED, 16'hFFFF);
        write_register(REG_UNUSED, 16'h0000);
        send_sample(16'sd2000, 16'sd2000, 16'sd4096);
        send_sample(-16'sd2000, 16'sd2000, -16'sd4096);
    endtask

    // phases at fixed corners and random values of the three registers
    task automatic test_setting_sweep();
        logic [NOISE_W-1:0] corners [7][3];
        corners = '{
            '{16'd0, 16'd0, 16'd0},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'd6554, 16'd6554, 16'd6554},
            '{16'd0, 16'hFFFF, 16'd1},
            '{16'hFFFF, 16'd0, 16'hFFFF},
            '{16'($urandom), 16'($urandom), 16'($urandom)},
            '{16'($urandom), 16'($urandom), 16'($urandom)}
        };
        for (int ph = 0; ph < 7; ph++) begin
            wait_for_estimates();
            write_settings(corners[ph][0], corners[ph][1], corners[ph][2]);
            repeat (45) send_random_sample();
        end
    endtask

    // long random run at reset-like settings, with drained pauses and a gap-free stretch
    task automatic test_random_traffic();
        wait_for_estimates();
        write_settings(16'd6554, 16'd6554, 16'd6554);
        for (int n = 0; n < 640; n++) begin
            steady_flow = (n >= 200 && n < 280);
            send_random_sample();
            if (n % 160 == 159) wait_for_estimates();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_zero_noise();
        test_angle_saturation();
        test_unmapped_register();
        test_setting_sweep();
        test_random_traffic();

        wait_for_estimates();
        // let any stray beat show up
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_estimates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
